/* rtl/rhc_pkg.sv */
// shared constants, types and widths for the rgb to hsv converter
package rhc_pkg;

    localparam int CHANNEL_BITS  = 8;
    localparam int HUE_FRAC_BITS = 6;

    localparam int CB        = CHANNEL_BITS;
    // hue units per 60 degrees and per full turn
    localparam int HUE_SCALE = 60 * (2 ** HUE_FRAC_BITS);
    localparam int HUE_FULL  = 360 * (2 ** HUE_FRAC_BITS);
    localparam int HUE_W     = $clog2(HUE_FULL);
    localparam int HSW       = HUE_W + 1;
    // hue fraction quotient bits, at most HUE_SCALE
    localparam int HQW       = $clog2(HUE_SCALE + 1);
    localparam int HNW       = CB + HQW;
    localparam int NST       = (HQW > CB) ? HQW : CB;
    localparam int QDEPTH    = 2;

    localparam int IN_W      = ((3 * CB + 7) / 8) * 8;
    localparam int OUT_W     = ((HUE_W + 2 * CB + 7) / 8) * 8;

    typedef enum logic [1:0] {
        SEXT_RED,
        SEXT_GREEN,
        SEXT_BLUE
    } t_sext;

    // classified pixel handed from front to back
    typedef struct packed {
        logic            gray;
        logic            neg;
        t_sext           sext;
        logic [CB-1:0]   bright;
        logic [CB-1:0]   delta;
        logic [HNW-1:0]  nh;
        logic [2*CB-1:0] ns;
    } t_cls;

endpackage

/* rtl/rgb_to_hsv_converter.sv */
// rgb to hsv converter top level: front classifier, queue, divider back end
// Converts one RGB pixel per word to hue (1/64 degree units), saturation and
// brightness (value). Brightness is the largest channel; black and gray pixels
// give hue 0 and saturation 0. Saturation is floor(delta*255/max); hue is chosen
// by sextant (red before green before blue on ties), floor-rounded, and wrapped
// into 0..359.98 degrees. Throughput is one pixel per clock, sustained, as long
// as the output side takes words. From input acceptance to output valid a pixel
// passes one front register, the two-word queue, twelve restoring divider
// stages (one quotient bit each, set by the hue quotient width) and the output
// register. Reset is synchronous and active low.
module rgb_to_hsv_converter (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // pixel input
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    // fields from bit 0: red, green, blue
    input  logic [rhc_pkg::IN_W-1:0]    i_s_axis_tdata,
    // hsv output
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    // fields from bit 0: hue, saturation, brightness, zero fill
    output logic [rhc_pkg::OUT_W-1:0]   o_m_axis_tdata
);
    import rhc_pkg::*;

    // front to queue
    logic             w_f_vld, w_f_rdy;
    t_cls             w_f_cls;
    // queue to back
    logic             w_b_vld, w_b_rdy;
    t_cls             w_b_cls;
    // results
    logic [HUE_W-1:0] w_hue;
    logic [CB-1:0]    w_sat, w_bri;

    // classify the pixel and build both dividends
    rhc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_red   (i_s_axis_tdata[CB-1:0]),
        .i_green (i_s_axis_tdata[2*CB-1:CB]),
        .i_blue  (i_s_axis_tdata[3*CB-1:2*CB]),
        .o_valid (w_f_vld),
        .i_ready (w_f_rdy),
        .o_cls   (w_f_cls)
    );

    // lets the front keep accepting while the back end is stalled
    rhc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_f_vld),
        .o_ready (w_f_rdy),
        .i_data  (w_f_cls),
        .o_valid (w_b_vld),
        .i_ready (w_b_rdy),
        .o_data  (w_b_cls)
    );

    // divider pipeline and output register
    rhc_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_b_vld),
        .o_ready  (w_b_rdy),
        .i_cls    (w_b_cls),
        .o_valid  (o_m_axis_tvalid),
        .i_ready  (i_m_axis_tready),
        .o_hue    (w_hue),
        .o_sat    (w_sat),
        .o_bright (w_bri)
    );

    assign o_m_axis_tdata = OUT_W'({w_bri, w_sat, w_hue});

    // hue always stays below one full turn
    a_hue_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (w_hue < HUE_W'(HUE_FULL)))
        else $error("hue out of range");

    // zero saturation only for gray, and gray has zero hue
    a_gray_hue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (w_sat == '0)) |-> (w_hue == '0))
        else $error("nonzero hue with zero saturation");

    // black has zero saturation
    a_black_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (w_bri == '0)) |-> (w_sat == '0))
        else $error("nonzero saturation on black");

endmodule

/* rtl/rhc_front.sv */
// front stage: max, min, sextant, channel difference and dividends
module rhc_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [rhc_pkg::CB-1:0] i_red,
    input  logic [rhc_pkg::CB-1:0] i_green,
    input  logic [rhc_pkg::CB-1:0] i_blue,
    output logic               o_valid,
    input  logic               i_ready,
    output rhc_pkg::t_cls      o_cls
);
    import rhc_pkg::*;

    logic          r_fvld, n_fvld;
    t_cls          r_cls, n_cls;
    logic [CB-1:0] w_mx, w_mn, w_abs, w_rg_mx, w_rg_mn;
    logic          w_acc;

    assign o_ready = !r_fvld || i_ready;
    assign w_acc   = i_valid && o_ready;
    assign o_valid = r_fvld;
    assign o_cls   = r_cls;

    always_comb begin
        w_rg_mx = (i_red >= i_green) ? i_red : i_green;
        w_rg_mn = (i_red <= i_green) ? i_red : i_green;
        w_mx    = (i_blue > w_rg_mx) ? i_blue : w_rg_mx;
        w_mn    = (i_blue < w_rg_mn) ? i_blue : w_rg_mn;
        n_cls.bright = w_mx;
        n_cls.delta  = w_mx - w_mn;
        n_cls.gray   = (w_mx == w_mn);
        priority if (i_red == w_mx) begin
            n_cls.sext = SEXT_RED;
            n_cls.neg  = i_green < i_blue;
            w_abs      = n_cls.neg ? i_blue - i_green : i_green - i_blue;
        end else if (i_green == w_mx) begin
            n_cls.sext = SEXT_GREEN;
            n_cls.neg  = i_blue < i_red;
            w_abs      = n_cls.neg ? i_red - i_blue : i_blue - i_red;
        end else begin
            n_cls.sext = SEXT_BLUE;
            n_cls.neg  = i_red < i_green;
            w_abs      = n_cls.neg ? i_green - i_red : i_red - i_green;
        end
        n_cls.nh = HNW'(w_abs) * HNW'(HUE_SCALE);
        // delta * (2^cb - 1)
        n_cls.ns = {n_cls.delta, CB'(0)} - {CB'(0), n_cls.delta};
        n_fvld   = w_acc || (r_fvld && !i_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fvld <= 1'b0;
        end else begin
            r_fvld <= n_fvld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_cls <= n_cls;
        end
    end

endmodule

/* rtl/rhc_queue.sv */
// two-word queue between front and back
module rhc_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  rhc_pkg::t_cls i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output rhc_pkg::t_cls o_data
);
    import rhc_pkg::*;

    localparam int PW = $clog2(QDEPTH);
    localparam int CW = $clog2(QDEPTH + 1);

    t_cls          r_mem [QDEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_count;
    logic          w_push, w_pop;

    assign o_ready = r_count != CW'(QDEPTH);
    assign o_valid = r_count != '0;
    assign o_data  = r_mem[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wp <= (r_wp == PW'(QDEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= (r_rp == PW'(QDEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_count <= r_count + CW'(w_push) - CW'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

/* rtl/rhc_back.sv */
// back end: pipelined restoring dividers for hue and saturation, final hue assembly
module rhc_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  rhc_pkg::t_cls         i_cls,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [rhc_pkg::HUE_W-1:0] o_hue,
    output logic [rhc_pkg::CB-1:0]    o_sat,
    output logic [rhc_pkg::CB-1:0]    o_bright
);
    import rhc_pkg::*;

    logic           w_en;
    logic           r_v  [NST];
    t_cls           r_c  [NST];
    logic [CB-1:0]  r_rh [NST];
    logic [HQW-1:0] r_qh [NST];
    logic [CB-1:0]  r_rs [NST];
    logic [CB-1:0]  r_qs [NST];

    logic             r_ovld;
    logic [HUE_W-1:0] r_hue, n_hue;
    logic [CB-1:0]    r_sat, r_bri;
    logic [HSW-1:0]   w_base, w_q;
    t_cls             w_lc;

    // whole pipeline moves when the output register is free
    assign w_en    = !r_ovld || i_ready;
    assign o_ready = w_en;

    genvar s;
    generate
        for (s = 0; s < NST; s++) begin : g_stage
            logic           w_vi;
            t_cls           w_ci;
            logic [CB-1:0]  w_rhi, w_rsi, w_rho, w_rso;
            logic [HQW-1:0] w_qhi, w_qho;
            logic [CB-1:0]  w_qsi, w_qso;

            if (s == 0) begin : g_first
                assign w_vi  = i_valid;
                assign w_ci  = i_cls;
                assign w_rhi = i_cls.nh[HNW-1:HQW];
                assign w_qhi = '0;
                assign w_rsi = i_cls.ns[2*CB-1:CB];
                assign w_qsi = '0;
            end else begin : g_next
                assign w_vi  = r_v[s-1];
                assign w_ci  = r_c[s-1];
                assign w_rhi = r_rh[s-1];
                assign w_qhi = r_qh[s-1];
                assign w_rsi = r_rs[s-1];
                assign w_qsi = r_qs[s-1];
            end

            if (s < HQW) begin : g_hstep
                logic [CB:0] w_th;
                assign w_th  = {w_rhi, w_ci.nh[HQW-1-s]};
                assign w_rho = (w_th >= {1'b0, w_ci.delta}) ?
                               CB'(w_th - {1'b0, w_ci.delta}) : w_th[CB-1:0];
                assign w_qho = {w_qhi[HQW-2:0], w_th >= {1'b0, w_ci.delta}};
            end else begin : g_hpass
                assign w_rho = w_rhi;
                assign w_qho = w_qhi;
            end

            if (s < CB) begin : g_sstep
                logic [CB:0] w_ts;
                assign w_ts  = {w_rsi, w_ci.ns[CB-1-s]};
                assign w_rso = (w_ts >= {1'b0, w_ci.bright}) ?
                               CB'(w_ts - {1'b0, w_ci.bright}) : w_ts[CB-1:0];
                assign w_qso = {w_qsi[CB-2:0], w_ts >= {1'b0, w_ci.bright}};
            end else begin : g_spass
                assign w_rso = w_rsi;
                assign w_qso = w_qsi;
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[s] <= 1'b0;
                end else if (w_en) begin
                    r_v[s] <= w_vi;
                end
            end

            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    r_c[s]  <= w_ci;
                    r_rh[s] <= w_rho;
                    r_qh[s] <= w_qho;
                    r_rs[s] <= w_rso;
                    r_qs[s] <= w_qso;
                end
            end
        end
    endgenerate

    // hue = sextant base +/- floor part, wrapped into one turn
    always_comb begin
        w_lc = r_c[NST-1];
        unique case (w_lc.sext)
            SEXT_RED:   w_base = '0;
            SEXT_GREEN: w_base = HSW'(2 * HUE_SCALE);
            SEXT_BLUE:  w_base = HSW'(4 * HUE_SCALE);
            default:    w_base = '0;
        endcase
        w_q = HSW'(r_qh[NST-1]) + HSW'(w_lc.neg && (r_rh[NST-1] != '0));
        if (w_lc.gray) begin
            n_hue = '0;
        end else if (!w_lc.neg) begin
            n_hue = HUE_W'(w_base + w_q);
        end else if (w_q > w_base) begin
            n_hue = HUE_W'(w_base + HSW'(HUE_FULL) - w_q);
        end else begin
            n_hue = HUE_W'(w_base - w_q);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (w_en) begin
            r_ovld <= r_v[NST-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_hue <= n_hue;
            r_sat <= w_lc.gray ? '0 : r_qs[NST-1];
            r_bri <= w_lc.bright;
        end
    end

    assign o_valid  = r_ovld;
    assign o_hue    = r_hue;
    assign o_sat    = r_sat;
    assign o_bright = r_bri;

endmodule
